/* src/pida_pkg.sv */
`default_nettype none

package pida_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int POS_W          = 6;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [POS_W-1:0]  position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [POS_W-1:0]   entry_count;
    } t_rsp;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             upd;
        logic [POS_W-1:0] pos;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* src/pida_cell.sv */
`default_nettype none

module pida_cell #(
    parameter int DW  = 32,
    parameter int IDX = 0
) (
    input  wire                   i_clk,
    input  pida_pkg::t_cell_cmd   i_cmd,
    input  wire  [DW-1:0]         i_wr_data,
    input  wire  [DW-1:0]         i_left,
    input  wire  [DW-1:0]         i_right,
    output logic [DW-1:0]         o_data
);
    import pida_pkg::*;

    logic [DW-1:0] r_data;
    logic [DW-1:0] n_data;
    logic          is_here;
    logic          is_above;

    assign is_here  = (int'(i_cmd.pos) == IDX);
    assign is_above = (IDX > int'(i_cmd.pos));

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (is_above) begin
                n_data = i_left;
            end else if (is_here) begin
                n_data = i_wr_data;
            end
        end else if (i_cmd.rem) begin
            if (is_above || is_here) begin
                n_data = i_right;
            end
        end else if (i_cmd.upd && is_here) begin
            n_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* src/positional_insert_delete_array.sv */
`default_nettype none

// Ordered array of signed values with insert, remove, update and read by position.
// A request is presented on i_req with start; it is taken at a rising edge where
// start is high and busy is low. busy stays low, so a new request may be given in
// every cycle: one transaction per clock cycle.
// Each request gives exactly one response on o_rsp, marked by o_strobe for a single
// cycle, in the cycle after the request is taken. The response carries the status,
// the read or removed value, and the entry count after the request.
// The entries live in a row of cells; on an insert the cells above the position load
// from their lower neighbor, on a remove those at or above it from their upper one,
// the matching cell takes the new value, and the shift completes at the accepting edge.
// The read path is a select over all cells, registered into the response.
// Reset clears the entry count and the strobe; cell contents are not cleared and
// only entries below the count are ever returned.
// The receiver cannot stall: a response not taken in its strobe cycle is gone.
module positional_insert_delete_array #(
    parameter int DEPTH      = pida_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pida_pkg::DATA_WIDTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  pida_pkg::t_req   i_req,
    output logic             o_strobe,
    output pida_pkg::t_rsp   o_rsp
);
    import pida_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_strobe;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;
    t_cell_cmd             cmd;
    logic                  accept;
    logic                  full;
    logic [MW-1:0]         pos_m;
    logic [MW-1:0]         cnt_m;
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] sel_data;
    logic signed [63:0]    val_ext;
    logic signed [63:0]    rd_ext;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CW'(DEPTH));
    assign pos_m  = MW'(i_req.position);
    assign cnt_m  = MW'(r_count);

    assign val_ext = 64'(i_req.value);
    assign wr_data = val_ext[DATA_WIDTH-1:0];

    always_comb begin
        status = ST_OK;
        if (i_req.req_type == OP_INSERT) begin
            if (full) begin
                status = ST_FULL;
            end else if (pos_m > cnt_m) begin
                status = ST_RANGE;
            end
        end else if (pos_m >= cnt_m) begin
            status = ST_RANGE;
        end
    end

    always_comb begin
        cmd.pos = i_req.position;
        cmd.ins = accept && (status == ST_OK) && (i_req.req_type == OP_INSERT);
        cmd.rem = accept && (status == ST_OK) && (i_req.req_type == OP_REMOVE);
        cmd.upd = accept && (status == ST_OK) && (i_req.req_type == OP_UPDATE);
    end

    always_comb begin
        sel_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (int'(i_req.position) == i) begin
                sel_data = sel_data | cell_q[i];
            end
        end
    end

    assign rd_ext = 64'($signed(sel_data));

    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (cmd.rem) begin
            n_count = r_count - 1'b1;
        end
        n_rsp.status      = status;
        n_rsp.read_value  = '0;
        if ((status == ST_OK) &&
            ((i_req.req_type == OP_REMOVE) || (i_req.req_type == OP_READ))) begin
            n_rsp.read_value = rd_ext[31:0];
        end
        n_rsp.entry_count = POS_W'(n_count);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;
        if (g == 0) begin : g_lo
            assign left_d = cell_q[g];
        end else begin : g_lo
            assign left_d = cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi
            assign right_d = cell_q[g];
        end else begin : g_hi
            assign right_d = cell_q[g+1];
        end
        pida_cell #(
            .DW  (DATA_WIDTH),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cmd),
            .i_wr_data (wr_data),
            .i_left    (left_d),
            .i_right   (right_d),
            .o_data    (cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
        end
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("response strobe missing after transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("response strobe without transaction");

    a_err_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (status != ST_OK)) |=> (r_count == $past(r_count)))
        else $error("rejected transaction changed the count");

endmodule

`default_nettype wire

/* test/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pida_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    logic signed [31:0] shadow_entries [DEPTH_DEF];
    int                 shadow_count = 0;
    t_rsp               pending_rsp [$];
    int                 mismatch_count = 0;
    int                 stall_cycles = 0;
    int                 idle_pct = 0;

    positional_insert_delete_array dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // Applies one accepted request to the shadow array and returns the response it must give.
    function automatic t_rsp predict_array_op(t_req r);
        t_rsp rsp;
        int   p;
        int   i;
        rsp = '0;
        rsp.status = ST_OK;
        p = int'(r.position);
        if (r.req_type == OP_INSERT) begin
            if (shadow_count >= DEPTH_DEF) begin
                rsp.status = ST_FULL;
            end else if (p > shadow_count) begin
                rsp.status = ST_RANGE;
            end else begin
                for (i = shadow_count; i > p; i--) begin
                    shadow_entries[i] = shadow_entries[i - 1];
                end
                shadow_entries[p] = r.value;
                shadow_count++;
            end
        end else if (p >= shadow_count) begin
            rsp.status = ST_RANGE;
        end else if (r.req_type == OP_REMOVE) begin
            rsp.read_value = shadow_entries[p];
            for (i = p; i + 1 < shadow_count; i++) begin
                shadow_entries[i] = shadow_entries[i + 1];
            end
            shadow_count--;
        end else if (r.req_type == OP_UPDATE) begin
            shadow_entries[p] = r.value;
        end else begin
            rsp.read_value = shadow_entries[p];
        end
        rsp.entry_count = shadow_count[POS_W-1:0];
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic send_request(logic [1:0] op, int pos, logic [31:0] val);
        t_req r;
        r.req_type = op;
        r.position = pos[POS_W-1:0];
        r.value    = val;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_rsp.push_back(predict_array_op(r));
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_for_responses();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_rsp.size() != 0);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (o_strobe === 1'b1) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("response with no request pending",
                                    32'(o_rsp.status), '0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.status !== want.status) begin
                        report_mismatch("status", 32'(o_rsp.status), 32'(want.status));
                    end
                    if (o_rsp.read_value !== want.read_value) begin
                        report_mismatch("read_value", o_rsp.read_value, want.read_value);
                    end
                    if (o_rsp.entry_count !== want.entry_count) begin
                        report_mismatch("entry_count", 32'(o_rsp.entry_count),
                                        32'(want.entry_count));
                    end
                end
            end else if (o_strobe !== 1'b0) begin
                report_mismatch("strobe", 32'(o_strobe), '0);
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic test_edges();
        send_request(OP_READ, 0, 32'h1234_5678);
        send_request(OP_REMOVE, 0, 32'h0);
        send_request(OP_UPDATE, 0, 32'hdead_beef);
        send_request(OP_INSERT, 1, 32'h1111_1111);
        send_request(OP_INSERT, 63, 32'h2222_2222);
        send_request(OP_INSERT, 0, 32'h8000_0000);
        send_request(OP_INSERT, 1, 32'h7fff_ffff);
        send_request(OP_INSERT, 0, 32'hffff_ffff);
        send_request(OP_INSERT, 1, 32'h0000_0000);
        send_request(OP_READ, 0, 32'h0);
        send_request(OP_READ, 1, 32'h0);
        send_request(OP_READ, 2, 32'h0);
        send_request(OP_READ, 3, 32'h0);
        send_request(OP_UPDATE, 2, 32'h5555_5555);
        send_request(OP_UPDATE, 4, 32'haaaa_aaaa);
        send_request(OP_READ, 63, 32'hffff_ffff);
        send_request(OP_REMOVE, 63, 32'h0);
        send_request(OP_REMOVE, 1, 32'h0);
        send_request(OP_READ, 1, 32'h0);
        send_request(OP_REMOVE, 2, 32'h0);
        send_request(OP_REMOVE, 0, 32'h0);
        send_request(OP_REMOVE, 0, 32'h0);
        send_request(OP_READ, 0, 32'h0);
    endtask

    task automatic test_full_array();
        while (shadow_count < DEPTH_DEF) begin
            send_request(OP_INSERT, $urandom_range(shadow_count), random_value());
        end
        send_request(OP_INSERT, 63, 32'h0bad_0001);
        send_request(OP_INSERT, DEPTH_DEF, 32'h0bad_0002);
        send_request(OP_INSERT, 0, 32'h0bad_0003);
        send_request(OP_READ, DEPTH_DEF - 1, 32'h0);
        send_request(OP_UPDATE, DEPTH_DEF - 1, 32'h8000_0001);
        send_request(OP_READ, DEPTH_DEF - 1, 32'h0);
        send_request(OP_READ, DEPTH_DEF, 32'h0);
        send_request(OP_REMOVE, DEPTH_DEF - 1, 32'h0);
        send_request(OP_INSERT, DEPTH_DEF - 1, 32'h7fff_fffe);
        send_request(OP_REMOVE, 0, 32'h0);
        send_request(OP_INSERT, 0, 32'h8000_0000);
    endtask

    task automatic test_random_traffic(int num_items, int gap_pct);
        logic [1:0] op;
        int         pos;
        int         roll;
        int         insert_pct;
        bit         filling;
        idle_pct = gap_pct;
        filling = (shadow_count < DEPTH_DEF / 2);
        repeat (num_items) begin
            sender_gap();
            if (shadow_count >= DEPTH_DEF) filling = 1'b0;
            else if (shadow_count == 0) filling = 1'b1;
            else if ($urandom_range(99) == 0) filling = !filling;
            if ($urandom_range(99) < 10) begin
                op  = 2'($urandom_range(3));
                pos = $urandom_range(63);
            end else begin
                roll = $urandom_range(99);
                insert_pct = filling ? 55 : 20;
                if (roll < insert_pct || shadow_count == 0) begin
                    op  = OP_INSERT;
                    pos = $urandom_range(shadow_count);
                end else begin
                    pos = $urandom_range(shadow_count - 1);
                    if (roll < insert_pct + (filling ? 20 : 50)) op = OP_REMOVE;
                    else if (roll[0]) op = OP_UPDATE;
                    else op = OP_READ;
                end
            end
            send_request(op, pos, random_value());
        end
        idle_pct = 0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        wait_for_responses();
        test_full_array();
        test_random_traffic(325, 0);
        wait_for_responses();
        test_random_traffic(325, 61);
        test_random_traffic(325, 0);
        wait_for_responses();
        test_random_traffic(325, 24);
        wait_for_responses();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
